// File: src/lru_key_value_cache_macros.svh
// Assertion macros shared by the cache RTL.
// With ASSERT_OFF defined every macro expands to nothing.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every rising edge outside reset.
`define LKV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be true outside reset.
`define LKV_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define LKV_ASSERT(label, clk, rst, prop, msg)
`define LKV_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// File: src/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

   // Store geometry.
   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int AGE_W       = IDX_W;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // Field widths.
   localparam int DATA_W     = 32;
   localparam int REQ_DATA_W = 2 * DATA_W;
   localparam int CAP_W      = 5;

   // Capacity register reset value.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Read value returned on a miss and on every put.
   localparam logic [DATA_W-1:0] NEG_ONE = '1;

   // Request queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOOK,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      logic             fire;
      logic [CNT_W-1:0] occupied;
   } back_status_type;

endpackage

`default_nettype wire

// File: src/lkv_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [63:0]      req_tdata,
   input  logic             req_tuser,
   output logic             push,
   output lkv_pkg::cmd_type push_cmd,
   input  logic             q_full
);
   import lkv_pkg::*;

   logic    hold_valid_ff;
   logic    hold_valid_in;
   cmd_type hold_cmd_ff;
   logic    accept;

   // The holding register drains into the queue whenever the queue has room.
   assign push       = hold_valid_ff && !q_full;
   assign push_cmd   = hold_cmd_ff;
   assign req_tready = !hold_valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Classify the request and split the packed data into key and value.
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_cmd_ff.op    <= req_tuser ? OP_PUT : OP_GET;
         hold_cmd_ff.key   <= req_tdata[DATA_W-1:0];
         hold_cmd_ff.value <= req_tdata[REQ_DATA_W-1:DATA_W];
      end
   end

endmodule

`default_nettype wire

// File: src/lkv_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lkv_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output lkv_pkg::cmd_type pop_cmd,
   output logic             empty
);
   import lkv_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // Pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: src/lkv_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [lkv_pkg::CAP_W-1:0] capacity,
   input  logic                     q_empty,
   input  lkv_pkg::cmd_type         pop_cmd,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,
   output logic                     rsp_tuser,
   output lkv_pkg::back_status_type status
);
   import lkv_pkg::*;

   // Per-entry store.
   logic             valid_ff [MAX_ENTRIES];
   logic             valid_in [MAX_ENTRIES];
   logic [DATA_W-1:0] key_ff  [MAX_ENTRIES];
   logic [DATA_W-1:0] key_in  [MAX_ENTRIES];
   logic [DATA_W-1:0] value_ff [MAX_ENTRIES];
   logic [DATA_W-1:0] value_in [MAX_ENTRIES];
   logic [AGE_W-1:0] age_ff   [MAX_ENTRIES];
   logic [AGE_W-1:0] age_in   [MAX_ENTRIES];
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;

   back_state_type   state_ff;
   back_state_type   state_in;
   cmd_type          cmd_ff;

   // Lookup results, one bit per entry.
   logic [MAX_ENTRIES-1:0] match_ff;
   logic [MAX_ENTRIES-1:0] match_in;
   logic [MAX_ENTRIES-1:0] free_ff;
   logic [MAX_ENTRIES-1:0] free_in;
   logic [MAX_ENTRIES-1:0] oldest_ff;
   logic [MAX_ENTRIES-1:0] oldest_in;
   logic [MAX_ENTRIES-1:0] invalid_vec;

   // Execute step.
   logic                   fire;
   logic                   take;
   logic                   hit;
   logic                   is_put;
   logic                   insert;
   logic                   do_upd;
   logic [CNT_W-1:0]       cap_eff;
   logic [CNT_W-1:0]       old_age;
   logic [MAX_ENTRIES-1:0] target;
   logic [DATA_W-1:0]      hit_value;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   assign fire   = (state_ff == BK_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign take   = !q_empty && ((state_ff == BK_IDLE) || fire);
   assign pop    = take;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_hit_ff;

   assign status.fire     = fire;
   assign status.occupied = occ_ff;

   // Sequencer: take a request, look it up, then apply it.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (take) begin
               state_in = BK_LOOK;
            end
         end
         BK_LOOK: begin
            state_in = BK_EXEC;
         end
         BK_EXEC: begin
            if (fire) begin
               state_in = take ? BK_LOOK : BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= pop_cmd;
      end
   end

   // Lookup: key compare, first free entry and least recent entry in parallel.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         invalid_vec[i] = !valid_ff[i];
         match_in[i]    = valid_ff[i] && (key_ff[i] == cmd_ff.key);
         oldest_in[i]   = valid_ff[i] && (CNT_W'(age_ff[i]) == (occ_ff - CNT_W'(1)));
      end
      free_in = invalid_vec & (~invalid_vec + {{(MAX_ENTRIES-1){1'b0}}, 1'b1});
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_LOOK) begin
         match_ff  <= match_in;
         free_ff   <= free_in;
         oldest_ff <= oldest_in;
      end
   end

   // Capacity clamped to one up to the store size.
   always_comb begin
      if (capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(capacity) > MAX_ENTRIES) begin
         cap_eff = CNT_W'(MAX_ENTRIES);
      end else begin
         cap_eff = CNT_W'(capacity);
      end
   end

   // Choose the entry to touch and the age that separates the entries to age.
   always_comb begin
      hit       = |match_ff;
      is_put    = (cmd_ff.op == OP_PUT);
      insert    = is_put && !hit && (occ_ff < cap_eff) && (|free_ff);
      target    = hit ? match_ff : (insert ? free_ff : oldest_ff);
      do_upd    = fire && (hit || is_put);
      old_age   = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         old_age   = old_age | (target[i] ? CNT_W'(age_ff[i]) : '0);
         hit_value = hit_value | (match_ff[i] ? value_ff[i] : '0);
      end
      if (insert) begin
         old_age = occ_ff;
      end
   end

   // Store update: the target becomes most recent, younger entries age by one.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         age_in[i]   = age_ff[i];
         if (do_upd) begin
            if (target[i]) begin
               age_in[i] = '0;
               if (is_put) begin
                  key_in[i]   = cmd_ff.key;
                  value_in[i] = cmd_ff.value;
               end
               if (insert) begin
                  valid_in[i] = 1'b1;
               end
            end else if (valid_ff[i] && (CNT_W'(age_ff[i]) < old_age)) begin
               age_in[i] = age_ff[i] + 1'b1;
            end
         end
      end
      occ_in = (fire && insert) ? occ_ff + 1'b1 : occ_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
         occ_ff <= '0;
      end else begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            age_ff[i]   <= age_in[i];
         end
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
      end
   end

   // Result register, loaded when the request is applied.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_hit_ff   <= hit;
         rsp_value_ff <= (hit && !is_put) ? hit_value : NEG_ONE;
      end
   end

endmodule

`default_nettype wire

// File: src/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none

`include "lru_key_value_cache_macros.svh"

// Fully associative key-value cache with least-recently-used replacement and
// sixteen entries. Each request is a get (tuser low) or a put (tuser high) on
// a 32-bit key; each request gives exactly one response, in request order,
// with tuser set when the key was present and tdata holding the stored value
// on a get hit and all ones otherwise. A request goes through the execution
// unit: a parallel key compare, then a store and recency update that waits
// on a full response register; the next request enters as one is applied. An
// input register and a two-entry queue let up to three requests wait ahead of
// the execution unit, and the response register lets one result wait for the
// consumer. The capacity register sets how many entries fill before eviction
// starts; values of zero act as one and values above sixteen as sixteen. Write
// it only while no request is in flight. The store is empty after reset.
module lru_key_value_cache (
   input  logic        clock,
   input  logic        reset,
   // Capacity register.
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] key, [63:32] value
   input  logic        req_tuser,   // [0] func
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] read_value
   output logic        rsp_tuser    // [0] hit
);
   import lkv_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   cmd_type          q_push_cmd;
   cmd_type          q_pop_cmd;
   back_status_type  back_status;
   logic             occ_over;
   logic             miss_rsp;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   lkv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .q_full     (q_full)
   );

   lkv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_pop_cmd),
      .empty    (q_empty)
   );

   lkv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .q_empty    (q_empty),
      .pop_cmd    (q_pop_cmd),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (back_status)
   );

   // Conditions that the checks below look at.
   assign occ_over = int'(back_status.occupied) > MAX_ENTRIES;
   assign miss_rsp = rsp_tvalid && !rsp_tuser;

   // Checks on the queue, the store and the response.
   `LKV_ASSERT_NEVER(a_queue_overflow, clock, reset, q_push && q_full, "request queue overflow")
   `LKV_ASSERT_NEVER(a_queue_underflow, clock, reset, q_pop && q_empty, "pop from empty queue")
   `LKV_ASSERT_NEVER(a_occ_range, clock, reset, occ_over, "occupancy beyond store size")
   `LKV_ASSERT(a_fire_rsp, clock, reset, back_status.fire |=> rsp_tvalid, "response missing")
   `LKV_ASSERT(a_miss_ones, clock, reset, miss_rsp |-> rsp_tdata == NEG_ONE, "miss not all ones")

endmodule

`default_nettype wire
